// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define WGM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define WGM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/wgm_pkg.sv =====
// Package: sizes, character codes, command codes and shared types of the glob matcher.
`default_nettype none

package wgm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CHAR_W      = 8;

  localparam logic [CHAR_W-1:0] STAR_CODE  = 8'd42;
  localparam logic [CHAR_W-1:0] QUERY_CODE = 8'd63;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_NAME    = 1'b1;

  typedef enum logic {
    ST_RUN,
    ST_FINISH
  } state_e;

  // Shared control for every position cell.
  typedef struct packed {
    logic seed;  // live set is only position zero this cycle
    logic step;  // take the advanced set into the active bits
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/wgm_cell.sv =====
// Pattern position cell: one stored character, one live bit, closure and advance links.
`default_nettype none

module wgm_cell
  import wgm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cell_ctl_t         ctl_i,
  input  wire logic              first_i,   // position zero
  input  wire logic              wr_en_i,
  input  wire logic              in_pat_i,  // position lies inside the loaded pattern
  input  wire logic [CHAR_W-1:0] char_i,
  input  wire logic              cl_i,      // star closure from the left neighbor
  input  wire logic              adv_i,     // advance from the left neighbor
  output logic                   cl_o,
  output logic                   adv_o,
  output logic                   closed_o
);

  logic [CHAR_W-1:0] chr_q, chr_d;
  logic              act_q, act_d;
  logic              act_eff, live, is_star, hit;

  always_comb begin
    act_eff  = ctl_i.seed ? first_i : act_q;
    closed_o = act_eff | cl_i;
    live     = closed_o & in_pat_i;
    is_star  = (chr_q == STAR_CODE);
    hit      = (chr_q == QUERY_CODE) || (chr_q == char_i);
    // a live star stays live and opens the next position
    cl_o     = live & is_star;
    adv_o    = live & ~is_star & hit;
    act_d    = ctl_i.step ? (cl_o | adv_i) : act_q;
    chr_d    = wr_en_i ? char_i : chr_q;
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wildcard_glob_matcher_unit.sv =====
// Top level: glob matcher, a row of pattern position cells with a small sequencer.
// Pattern and non-final name beats: one per cycle. Final name beat: followed by a closure
// state that re-runs star closure along the row to read the end position; input stalls
// then, and longer while an earlier result beat is still held by the receiver.
// Result beat is registered out of the closure state once the result slot is free.
// Reset: empty pattern, no result pending, live set is only position zero.
`default_nettype none

module wildcard_glob_matcher_unit
  import wgm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // item channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              cmd_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic              last_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   matched_o,
  output logic                   pattern_overflow_o
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;          // characters in the stored pattern
  logic             too_long_q, too_long_d; // pattern was truncated
  logic             restart_q, restart_d;   // next pattern beat opens a new pattern
  logic             seed_q, seed_d;         // live set is only position zero
  logic             act_end_q, act_end_d;   // live bit of the end position

  logic             out_valid_q, out_valid_d;
  logic             matched_q, matched_d;
  logic             ovf_q, ovf_d;

  // --------------------------------------------------------------------------
  // Cell row wiring
  // --------------------------------------------------------------------------
  cell_ctl_t              ctl;
  logic [MAX_PATTERN-1:0] cl, adv, wr_en, in_pat;
  logic [MAX_PATTERN:0]   closed;           // closed live set, end position on top
  logic                   in_fire, out_free;
  logic [LEN_W-1:0]       wr_idx;
  logic                   wr_ok;

  // input is held off only while the end position is read out
  assign in_stall_o = (state_q == ST_FINISH);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // name beat: closure then advance, all cells at once
  assign ctl = '{seed: seed_q, step: in_fire & (cmd_i == CMD_NAME)};

  // Target slot of a pattern beat: a fresh pattern starts at slot zero.
  assign wr_idx = restart_q ? '0 : len_q;
  assign wr_ok  = (wr_idx < LEN_W'(MAX_PATTERN));

  for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
    logic cl_in, adv_in;

    assign wr_en[gi]  = in_fire & (cmd_i == CMD_PATTERN) & wr_ok & (wr_idx == LEN_W'(gi));
    assign in_pat[gi] = (LEN_W'(gi) < len_q);

    if (gi == 0) begin : g_head
      assign cl_in  = 1'b0;
      assign adv_in = 1'b0;
    end else begin : g_link
      assign cl_in  = cl[gi-1];
      assign adv_in = adv[gi-1];
    end

    wgm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .first_i  (gi == 0),
      .wr_en_i  (wr_en[gi]),
      .in_pat_i (in_pat[gi]),
      .char_i   (char_code_i),
      .cl_i     (cl_in),
      .adv_i    (adv_in),
      .cl_o     (cl[gi]),
      .adv_o    (adv[gi]),
      .closed_o (closed[gi])
    );
  end

  // End position: no character, only reached by advance or closure from the last cell.
  assign closed[MAX_PATTERN] = (act_end_q & ~seed_q) | cl[MAX_PATTERN-1];

  // --------------------------------------------------------------------------
  // Sequencer: next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    too_long_d  = too_long_q;
    restart_d   = restart_q;
    seed_d      = seed_q;
    act_end_d   = act_end_q;
    matched_d   = matched_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q & out_stall_i;

    case (state_q)
      ST_RUN: begin
        if (in_fire) begin
          if (cmd_i == CMD_PATTERN) begin
            if (restart_q) begin
              too_long_d = 1'b0;
            end
            if (wr_ok) begin
              len_d = wr_idx + LEN_W'(1);
            end else begin
              len_d      = wr_idx;
              too_long_d = 1'b1;
            end
            restart_d = last_i;
            seed_d    = 1'b1;   // any name in progress is dropped
          end else begin
            // cells step on this edge; end position takes the last cell's advance
            seed_d    = 1'b0;
            act_end_d = adv[MAX_PATTERN-1];
            if (last_i) begin
              state_d = ST_FINISH;
            end
          end
        end
      end
      ST_FINISH: begin
        // closure of the final set settles along the row; read the end slot
        if (out_free) begin
          out_valid_d = 1'b1;
          matched_d   = closed[len_q];
          ovf_d       = too_long_q;
          seed_d      = 1'b1;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      len_q       <= '0;
      too_long_q  <= 1'b0;
      restart_q   <= 1'b1;
      seed_q      <= 1'b1;
      act_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      too_long_q  <= too_long_d;
      restart_q   <= restart_d;
      seed_q      <= seed_d;
      act_end_q   <= act_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    ovf_q     <= ovf_d;
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_q;

endmodule

`default_nettype wire

// ===== sv/wgm_checker.sv =====
// Port-level checker for the glob matcher and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module wgm_checker
  import wgm_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              cmd_i,
  input wire logic [CHAR_W-1:0] char_code_i,
  input wire logic              last_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              matched_o,
  input wire logic              pattern_overflow_o
);

  logic name_end_beat;
  assign name_end_beat = in_valid_i & ~in_stall_o & (cmd_i == CMD_NAME) & last_i;

  // stalled result beat holds
  `WGM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(matched_o) && $stable(pattern_overflow_o), "stalled result beat changed")
  // final name beat is followed by the closure cycle
  `WGM_ASSERT(a_end_stall, name_end_beat |=> in_stall_o, "no closure cycle after final name beat")
  // a new result only comes out of a closure cycle
  `WGM_ASSERT(a_res_src, $rose(out_valid_o) |-> $past(in_stall_o), "result beat without final name beat")
  // closure cycle is left when the result slot is free
  `WGM_ASSERT(a_stall_len, in_stall_o && !(out_valid_o && out_stall_i) |=> !in_stall_o, "input stall too long")
  // reset empties the result slot
  `WGM_ASSERT_RST(a_rst_out, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind wildcard_glob_matcher_unit wgm_checker u_wgm_checker (.*);

`default_nettype wire
